### rtl/core/pppenc_pkg.sv
`timescale 1ns / 1ps

package pppenc_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;
	localparam logic [7:0]  ESC_XOR   = 8'h20;
	localparam logic [15:0] FCS_INIT  = 16'hFFFF;
	localparam logic [15:0] FCS_POLY  = 16'h8408;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       byte_present;
		logic       frame_end;
	} in_word_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       run_last;
		logic       closing_flag;
	} out_word_t;

	typedef struct packed {
		logic        open_flag;
		logic        byte_present;
		logic [7:0]  payload_byte;
		logic        frame_end;
		logic [15:0] fcs;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} queue_rd_t;

	typedef enum logic [2:0] {
		PH_OPEN,
		PH_DATA,
		PH_FCS_LO,
		PH_FCS_HI,
		PH_CLOSE
	} phase_t;

	function automatic logic [15:0] fcs_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic needs_escape(input logic [7:0] b);
		return (b < ESC_XOR) || (b == FLAG_BYTE) || (b == ESC_BYTE);
	endfunction

endpackage

### rtl/core/pppenc_front.sv
`timescale 1ns / 1ps

module pppenc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pppenc_pkg::in_word_t in_word,
	input  logic                 q_full,
	output logic                 push,
	output pppenc_pkg::job_t     push_job
);
	import pppenc_pkg::*;

	logic [15:0] crc_q;
	logic        open_q;
	logic [15:0] crc_next;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (in_word.byte_present || in_word.frame_end);

	assign crc_next = in_word.byte_present ? fcs_update(crc_q, in_word.payload_byte) : crc_q;

	always_comb begin
		push_job.open_flag    = !open_q;
		push_job.byte_present = in_word.byte_present;
		push_job.payload_byte = in_word.payload_byte;
		push_job.frame_end    = in_word.frame_end;
		push_job.fcs          = ~crc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= FCS_INIT;
			open_q <= 1'b0;
		end else if (push) begin
			if (in_word.frame_end) begin
				crc_q  <= FCS_INIT;
				open_q <= 1'b0;
			end else begin
				crc_q  <= crc_next;
				open_q <= 1'b1;
			end
		end
	end

endmodule

### rtl/core/pppenc_queue.sv
`timescale 1ns / 1ps

module pppenc_queue #(
	parameter int DEPTH = pppenc_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pppenc_pkg::job_t      push_job,
	output logic                  full,
	input  logic                  pop,
	output pppenc_pkg::queue_rd_t rd
);
	import pppenc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/pppenc_back.sv
`timescale 1ns / 1ps

module pppenc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pppenc_pkg::queue_rd_t rd,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pppenc_pkg::out_word_t out_word
);
	import pppenc_pkg::*;

	job_t      job_q;
	logic      busy_q;
	phase_t    phase_q;
	logic      esc_q;
	logic      out_valid_q;
	out_word_t out_q;

	phase_t    phase_d;
	phase_t    first_phase;
	logic      esc_d;
	logic      busy_d;
	logic      emit;
	logic      escapable;
	logic      closing;
	logic      job_done;
	logic [7:0] cur_byte;
	out_word_t word_d;

	assign out_valid = out_valid_q;
	assign out_word  = out_q;
	assign emit      = busy_q && (!out_valid_q || out_ready);
	assign pop       = !busy_q && rd.valid;

	always_comb begin
		if (rd.job.open_flag) begin
			first_phase = PH_OPEN;
		end else if (rd.job.byte_present) begin
			first_phase = PH_DATA;
		end else begin
			first_phase = PH_FCS_LO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_OPEN;
			esc_q   <= 1'b0;
		end else if (pop) begin
			busy_q  <= 1'b1;
			phase_q <= first_phase;
			esc_q   <= 1'b0;
		end else begin
			busy_q  <= busy_d;
			phase_q <= phase_d;
			esc_q   <= esc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= rd.job;
		end
	end

	always_comb begin
		cur_byte  = FLAG_BYTE;
		escapable = 1'b0;
		closing   = 1'b0;
		job_done  = 1'b0;
		phase_d   = phase_q;
		esc_d     = esc_q;
		busy_d    = busy_q;
		case (phase_q)
			PH_OPEN: begin
				cur_byte = FLAG_BYTE;
			end
			PH_DATA: begin
				cur_byte  = job_q.payload_byte;
				escapable = 1'b1;
			end
			PH_FCS_LO: begin
				cur_byte  = job_q.fcs[7:0];
				escapable = 1'b1;
			end
			PH_FCS_HI: begin
				cur_byte  = job_q.fcs[15:8];
				escapable = 1'b1;
			end
			PH_CLOSE: begin
				cur_byte = FLAG_BYTE;
				closing  = 1'b1;
			end
			default: begin
				cur_byte = FLAG_BYTE;
			end
		endcase

		if (escapable && needs_escape(cur_byte) && !esc_q) begin
			word_d.line_byte    = ESC_BYTE;
			word_d.run_last     = 1'b0;
			word_d.closing_flag = 1'b0;
			if (emit) begin
				esc_d = 1'b1;
			end
		end else begin
			case (phase_q)
				PH_OPEN: begin
					if (job_q.byte_present) begin
						phase_d = PH_DATA;
					end else begin
						phase_d = PH_FCS_LO;
					end
				end
				PH_DATA: begin
					phase_d  = PH_FCS_LO;
					job_done = !job_q.frame_end;
				end
				PH_FCS_LO: phase_d = PH_FCS_HI;
				PH_FCS_HI: phase_d = PH_CLOSE;
				PH_CLOSE:  job_done = 1'b1;
				default:   job_done = 1'b1;
			endcase
			word_d.line_byte    = esc_q ? (cur_byte ^ ESC_XOR) : cur_byte;
			word_d.run_last     = job_done;
			word_d.closing_flag = closing;
			if (emit) begin
				esc_d = 1'b0;
				if (job_done) begin
					busy_d = 1'b0;
				end
			end else begin
				phase_d = phase_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= word_d;
		end
	end

endmodule

### rtl/core/ppp_async_frame_encoder_core.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake              Word
// in       in   in_valid / in_ready    in_word  (payload_byte, byte_present, frame_end)
// out      out  out_valid / out_ready  out_word (line_byte, run_last, closing_flag)
//
// The front takes one input word per cycle while the job queue has room and updates
// the FCS in the same cycle; idle words are taken and dropped.
// The back drives one line byte per cycle while busy with a job and not stalled; it
// loads each job from the queue in a step of its own and pops no new job until done.
// Reset clears the FCS to all ones, closes the frame and empties queue and output.
// A stalled output holds the back; the queue lets the front keep taking words until full.
module ppp_async_frame_encoder_core #(
	parameter int QUEUE_DEPTH = pppenc_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pppenc_pkg::in_word_t  in_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pppenc_pkg::out_word_t out_word
);
	import pppenc_pkg::*;

	logic      q_full;
	logic      push;
	job_t      push_job;
	logic      pop;
	queue_rd_t rd;

	pppenc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	pppenc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.rd       (rd)
	);

	pppenc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (rd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

### rtl/core/pppenc_checker.sv
`timescale 1ns / 1ps

module pppenc_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input pppenc_pkg::in_word_t  in_word,
	input logic                  out_valid,
	input logic                  out_ready,
	input pppenc_pkg::out_word_t out_word
);
	import pppenc_pkg::*;

	logic esc_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_seen_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			esc_seen_q <= (out_word.line_byte == ESC_BYTE);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_word))
		else $error("input word changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.closing_flag |->
			out_word.line_byte == FLAG_BYTE && out_word.run_last)
		else $error("closing flag is not a final flag byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.line_byte >= ESC_XOR)
		else $error("control byte left unescaped on the line");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && esc_seen_q |->
			out_word.line_byte != FLAG_BYTE && out_word.line_byte != ESC_BYTE
			&& !out_word.closing_flag)
		else $error("escape byte not followed by an escaped data byte");

endmodule

bind ppp_async_frame_encoder_core pppenc_checker u_pppenc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);
